// ===== design/smt_pkg.sv =====
// Package for the seismic trace mute and taper block.
// Item types, register indexes, mode codes and the cosine weight table.
// Used by seismic_trace_mute_taper; depends on nothing else.
package smt_pkg;

   localparam int MAX_SAMPLES = 4096;
   localparam int MAX_TAPER   = 256;
   localparam int SAMPLE_BITS = 24;
   localparam int COS_ENTRIES = 256;
   localparam int CSR_BITS    = 24;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;
   localparam logic [16:0] W_ONE   = 17'd65536;

   // register indexes
   localparam logic [2:0] REG_MUTE_MODE      = 3'd0;
   localparam logic [2:0] REG_TAPER_FORM     = 3'd1;
   localparam logic [2:0] REG_TAPER_LENGTH   = 3'd2;
   localparam logic [2:0] REG_TAPER_RECIP    = 3'd3;
   localparam logic [2:0] REG_TRACE_LENGTH   = 3'd4;
   localparam logic [2:0] REG_KILL_ENABLE    = 3'd5;
   localparam logic [2:0] REG_INDICATE_VALUE = 3'd6;
   localparam logic [2:0] REG_INDICATE_WIDTH = 3'd7;

   // mute modes
   localparam logic [2:0] MODE_FRONT = 3'd0;
   localparam logic [2:0] MODE_END   = 3'd1;
   localparam logic [2:0] MODE_IN    = 3'd2;
   localparam logic [2:0] MODE_OUT   = 3'd3;
   localparam logic [2:0] MODE_IND1  = 3'd4;
   localparam logic [2:0] MODE_IND2  = 3'd5;

   // taper placement and cosine form codes
   localparam logic [1:0] PLACE_AT_MIN       = 2'd0;
   localparam logic [1:0] PLACE_AT_CENTER    = 2'd1;
   localparam logic [1:0] PLACE_AT_MAX       = 2'd2;
   localparam logic [2:0] FORM_COS_CENTER    = 3'd4;
   localparam logic [2:0] FORM_COS_FIRST     = 3'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic [11:0]                   sample_index;
      logic [12:0]                   mute_first;
      logic [12:0]                   mute_second;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_value;
      logic                          trace_killed;
      logic                          last_out;
   } rsp_type;

   typedef logic [16:0] cos_tab_type [0:COS_ENTRIES];

   // (1 - cos(pi*j/N))/2 in Q16, Taylor series in Q30, evaluated at elaboration
   function automatic cos_tab_type build_cos();
      cos_tab_type tab;
      logic [63:0] y, y2, term, r;
      logic signed [63:0] sum, v;
      logic neg;
      for (int j = 0; j <= COS_ENTRIES; j++) begin
         r   = 64'(j);
         neg = 1'b0;
         if (2 * j > COS_ENTRIES) begin
            r   = 64'(COS_ENTRIES - j);
            neg = 1'b1;
         end
         y    = r * PI_Q30 / COS_ENTRIES;
         y2   = (y * y) >> 30;
         term = ONE_Q30;
         sum  = $signed(ONE_Q30);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * y2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
         end
         if (neg) sum = -sum;
         v = $signed(ONE_Q30) - sum;
         if (v < 0) v = 0;
         if (v > 2 * $signed(ONE_Q30)) v = 2 * $signed(ONE_Q30);
         tab[j] = 17'((v + 64'sd16384) >>> 15);
      end
      return tab;
   endfunction

   localparam cos_tab_type COS_TABLE = build_cos();

endpackage

// ===== design/seismic_trace_mute_taper.sv =====
// Seismic trace mute with linear or cosine taper, one sample item per cycle.
// Uses smt_pkg for item types, register codes and the cosine weight table.
//
//  channel  ports                          handshake
//  -------  -----------------------------  -------------------------------
//  input    start, busy, req_data          taken when start & !busy
//  result   rsp_strobe, rsp_data           one cycle strobe, no back-pressure
//  config   csr_valid, csr_ready, csr_*    written when valid & ready
//
// Five register stages: geometry, taper position, weight lookup, weight
// product, sample scaling; one item per cycle. busy is always low and
// csr_ready always high. Synchronous reset clears the valid bits and
// loads the register defaults.
module seismic_trace_mute_taper (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  smt_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output smt_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [smt_pkg::CSR_BITS-1:0]  csr_data
);

   localparam int SB = smt_pkg::SAMPLE_BITS;

   // configuration
   logic [2:0]  mute_mode_ff, taper_form_ff;
   logic [8:0]  taper_length_ff;
   logic [16:0] taper_recip_ff;
   logic [12:0] trace_length_ff, indicate_width_ff;
   logic        kill_enable_ff;
   logic signed [23:0] indicate_value_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_mode_ff      <= smt_pkg::MODE_FRONT;
         taper_form_ff     <= smt_pkg::FORM_COS_CENTER;
         taper_length_ff   <= '0;
         taper_recip_ff    <= smt_pkg::W_ONE;
         trace_length_ff   <= 13'd4096;
         kill_enable_ff    <= 1'b0;
         indicate_value_ff <= '0;
         indicate_width_ff <= 13'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            smt_pkg::REG_MUTE_MODE:      mute_mode_ff      <= csr_data[2:0];
            smt_pkg::REG_TAPER_FORM:     taper_form_ff     <= csr_data[2:0];
            smt_pkg::REG_TAPER_LENGTH:   taper_length_ff   <= csr_data[8:0];
            smt_pkg::REG_TAPER_RECIP:    taper_recip_ff    <= csr_data[16:0];
            smt_pkg::REG_TRACE_LENGTH:   trace_length_ff   <= csr_data[12:0];
            smt_pkg::REG_KILL_ENABLE:    kill_enable_ff    <= csr_data[0];
            smt_pkg::REG_INDICATE_VALUE: indicate_value_ff <= $signed(csr_data[23:0]);
            smt_pkg::REG_INDICATE_WIDTH: indicate_width_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // derived settings
   logic [2:0] form;
   logic       cosine;
   logic [1:0] place;
   logic signed [15:0] tl, half, nn;
   always_comb begin
      form   = (taper_form_ff > 3'd5) ? smt_pkg::FORM_COS_CENTER : taper_form_ff;
      cosine = form >= smt_pkg::FORM_COS_FIRST;
      place  = cosine ? 2'(form - smt_pkg::FORM_COS_FIRST) : form[1:0];
      tl     = (taper_length_ff > 9'd256) ? 16'sd256 : $signed({7'd0, taper_length_ff});
      half   = tl >>> 1;
      if (trace_length_ff == 13'd0) nn = 16'sd0;
      else if (trace_length_ff > 13'd4096) nn = 16'sd4095;
      else nn = $signed({3'd0, trace_length_ff}) - 16'sd1;
   end

   // ---------------- stage 1: geometry
   logic               v1_ff, act1_ff, mut1_ff, kill1_ff, spk1_ff, en1_ff, en2_ff, last1_ff;
   logic signed [SB-1:0] s1_ff;
   logic [8:0]         k1_ff, k2_ff;
   logic               act1_in, mut1_in, kill1_in, spk1_in, en1_in, en2_in;
   logic [8:0]         k1_in, k2_in;

   always_comb begin
      logic signed [15:0] i, a, b, ms, me, ts1, te1, ts2, te2, fin, fz, sum, w, lo, hi, m;
      logic skip;
      i = $signed({4'd0, req_data.sample_index});
      a = $signed({3'd0, req_data.mute_first});
      b = $signed({3'd0, req_data.mute_second});
      w = $signed({3'd0, indicate_width_ff});
      act1_in = i <= nn;
      mut1_in = 1'b0; kill1_in = 1'b0; spk1_in = 1'b0;
      en1_in = 1'b0; en2_in = 1'b0; k1_in = '0; k2_in = '0;
      ms = '0; me = '0; ts1 = '0; te1 = '0; ts2 = '0; te2 = '0;
      fin = nn; fz = '0; sum = '0; lo = '0; hi = '0; m = '0; skip = 1'b0;
      unique case (mute_mode_ff)
         smt_pkg::MODE_FRONT: begin
            me = a - 16'sd1;
            if (tl > 0) begin
               ts1 = (place == smt_pkg::PLACE_AT_MAX) ? me - tl + 16'sd1 :
                     (place == smt_pkg::PLACE_AT_CENTER) ? me - half + 16'sd1 : me + 16'sd1;
               te1 = ts1 + tl;
               me  = ts1 - 16'sd1;
               en1_in = i >= ts1 && i < te1;
               k1_in  = 9'(cosine ? i - ts1 : i - ts1 + 16'sd1);
            end
            kill1_in = me >= nn;
            mut1_in  = i <= me;
         end
         smt_pkg::MODE_END: begin
            ms = a;
            if (tl > 0) begin
               ts2 = (place == smt_pkg::PLACE_AT_MAX) ? ms :
                     (place == smt_pkg::PLACE_AT_CENTER) ? ms - half : ms - tl;
               te2 = ts2 + tl;
               ms  = te2;
               en2_in = i >= ts2 && i < te2;
               k2_in  = 9'(te2 - i);
            end
            kill1_in = ms <= 0;
            mut1_in  = i >= ms;
         end
         smt_pkg::MODE_IN: begin
            ms = a; me = b;
            if (tl > 0) begin
               ts1 = (place == smt_pkg::PLACE_AT_MAX) ? ms :
                     (place == smt_pkg::PLACE_AT_CENTER) ? ms - half : ms - tl;
               ts2 = (place == smt_pkg::PLACE_AT_MAX) ? me - tl + 16'sd1 :
                     (place == smt_pkg::PLACE_AT_CENTER) ? me - half + 16'sd1 : me + 16'sd1;
               te1 = ts1 + tl; ms = te1;
               te2 = ts2 + tl; me = ts2 - 16'sd1;
               skip = ts1 >= te2;
               if (te1 > ts2) begin
                  // crossing tapers meet at the midpoint, rounded toward zero
                  sum = te1 + ts2;
                  fin = (sum + $signed({15'd0, sum[15]})) >>> 1;
                  fz  = fin;
               end
               en1_in = !skip && i >= ts1 && i < te1 && i <= fin;
               k1_in  = 9'(te1 - i);
               en2_in = !skip && i >= ts2 && i < te2 && i >= fz;
               k2_in  = 9'(cosine ? i - ts2 : i - ts2 + 16'sd1);
            end
            kill1_in = !skip && me >= nn && ms <= 0;
            mut1_in  = !skip && i >= ms && i <= me;
         end
         smt_pkg::MODE_OUT: begin
            ms = a - 16'sd1; me = b + 16'sd1;
            if (tl > 0) begin
               ts1 = (place == smt_pkg::PLACE_AT_MAX) ? ms - tl + 16'sd1 :
                     (place == smt_pkg::PLACE_AT_CENTER) ? ms - half + 16'sd1 : ms + 16'sd1;
               ts2 = (place == smt_pkg::PLACE_AT_MAX) ? me :
                     (place == smt_pkg::PLACE_AT_CENTER) ? me - half : me - tl;
               te1 = ts1 + tl; ms = ts1 - 16'sd1;
               te2 = ts2 + tl; me = te2;
               skip = te1 < 0 && ts2 > nn;
               en1_in = !skip && i >= ts1 && i < te1;
               k1_in  = 9'(cosine ? i - ts1 : i - ts1 + 16'sd1);
               en2_in = !skip && i >= ts2 && i < te2;
               k2_in  = 9'(te2 - i);
            end
            kill1_in = !skip && ms >= me;
            mut1_in  = !skip && (i <= ms || i >= me);
         end
         smt_pkg::MODE_IND1, smt_pkg::MODE_IND2: begin
            m  = a;
            lo = (m - w < 0) ? 16'sd0 : m - w;
            hi = (m + w < nn) ? m + w : nn;
            spk1_in = i >= lo && i < hi;
            if (mute_mode_ff == smt_pkg::MODE_IND2) begin
               m  = b;
               lo = (m - w < 0) ? 16'sd0 : m - w;
               hi = (m + w < nn) ? m + w : nn;
               spk1_in = spk1_in || (i >= lo && i < hi);
            end
         end
         default: ;
      endcase
      kill1_in = kill1_in && kill_enable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= start;
      act1_ff <= act1_in; mut1_ff <= mut1_in; kill1_ff <= kill1_in; spk1_ff <= spk1_in;
      en1_ff <= en1_in; en2_ff <= en2_in; k1_ff <= k1_in; k2_ff <= k2_in;
      s1_ff <= req_data.sample_value; last1_ff <= req_data.last_sample;
   end

   // ---------------- stage 2: taper position x = k * recip, saturated
   logic               v2_ff, act2_ff, mut2_ff, kill2_ff, spk2_ff, en1b_ff, en2b_ff, last2_ff;
   logic signed [SB-1:0] s2_ff;
   logic [16:0]        x1_ff, x2_ff;
   logic [25:0]        p1, p2;
   assign p1 = k1_ff * taper_recip_ff;
   assign p2 = k2_ff * taper_recip_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      x1_ff <= (p1 > 26'd65536) ? smt_pkg::W_ONE : p1[16:0];
      x2_ff <= (p2 > 26'd65536) ? smt_pkg::W_ONE : p2[16:0];
      act2_ff <= act1_ff; mut2_ff <= mut1_ff; kill2_ff <= kill1_ff; spk2_ff <= spk1_ff;
      en1b_ff <= en1_ff; en2b_ff <= en2_ff; s2_ff <= s1_ff; last2_ff <= last1_ff;
   end

   // ---------------- stage 3: weight lookup
   logic               v3_ff, act3_ff, mut3_ff, kill3_ff, spk3_ff, last3_ff;
   logic signed [SB-1:0] s3_ff;
   logic [16:0]        wa_ff, wb_ff;
   logic [17:0]        ix1, ix2;
   assign ix1 = 18'(x1_ff) + 18'd128;
   assign ix2 = 18'(x2_ff) + 18'd128;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      wa_ff <= !en1b_ff ? smt_pkg::W_ONE :
               cosine ? smt_pkg::COS_TABLE[ix1[16:8]] : x1_ff;
      wb_ff <= !en2b_ff ? smt_pkg::W_ONE :
               cosine ? smt_pkg::COS_TABLE[ix2[16:8]] : x2_ff;
      act3_ff <= act2_ff; mut3_ff <= mut2_ff; kill3_ff <= kill2_ff; spk3_ff <= spk2_ff;
      s3_ff <= s2_ff; last3_ff <= last2_ff;
   end

   // ---------------- stage 4: combined weight; unity on one side is exact
   logic               v4_ff, act4_ff, mut4_ff, kill4_ff, spk4_ff, last4_ff;
   logic signed [SB-1:0] s4_ff;
   logic [16:0]        w4_ff;
   logic [33:0]        wp;
   assign wp = wa_ff * wb_ff + 34'd32768;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      w4_ff <= wp[32:16];
      act4_ff <= act3_ff; mut4_ff <= mut3_ff; kill4_ff <= kill3_ff; spk4_ff <= spk3_ff;
      s4_ff <= s3_ff; last4_ff <= last3_ff;
   end

   // ---------------- stage 5: scale, select, result register
   logic signed [SB+18:0] sp;
   logic signed [SB-1:0]  r5_in;
   assign sp = s4_ff * $signed({2'b00, w4_ff}) + (SB+19)'(32768);

   always_comb begin
      priority if (kill4_ff) r5_in = '0;
      else if (spk4_ff)      r5_in = indicate_value_ff;
      else if (!act4_ff)     r5_in = s4_ff;
      else if (mut4_ff)      r5_in = '0;
      else                   r5_in = sp[SB+15:16];
   end

   logic    rsp_strobe_ff;
   smt_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else rsp_strobe_ff <= v4_ff;
      rsp_ff.out_value    <= r5_in;
      rsp_ff.trace_killed <= kill4_ff;
      rsp_ff.last_out     <= last4_ff;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== test/seismic_trace_mute_taper_tb.sv =====
// Testbench for seismic_trace_mute_taper: directed rows, then corner and random
// mute settings on trace-shaped streams, checked by rows or a local mute/taper predictor.
// Depends on smt_pkg and the seismic_trace_mute_taper RTL.
`timescale 1ns / 100ps

module seismic_trace_mute_taper_tb;

   localparam int N_PHASES    = 20;
   localparam int PHASE_ITEMS = 62;
   localparam int CALM_AFTER  = 1100;

   typedef struct {
      logic [23:0] sv;
      int          idx;
      int          a;
      int          b;
      bit          last;
      bit          typed;
      logic [23:0] ev;
      bit          ek;
   } dir_row_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           start = 1'b0;
   logic           busy;
   smt_pkg::req_type req_data = '0;
   logic           rsp_strobe;
   smt_pkg::rsp_type rsp_data;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [2:0]     csr_index = '0;
   logic [smt_pkg::CSR_BITS-1:0] csr_data = '0;

   // register copies for prediction
   logic [2:0]  mode_r;
   logic [2:0]  form_r;
   logic [8:0]  tlen_r;
   logic [16:0] recip_r;
   logic [12:0] trlen_r;
   logic        kill_r;
   logic [23:0] ival_r;
   logic [12:0] iwidth_r;

   logic [16:0] cos_w [0:smt_pkg::COS_ENTRIES];
   smt_pkg::rsp_type pending_samples [$];
   int          n_items, n_results, n_errors;

   seismic_trace_mute_taper i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // raised-cosine weights, Q30 Taylor series reduced to the first quadrant
   function automatic void fill_cos_weights();
      longint unsigned y, y2, term, r;
      longint          sum, v;
      bit              neg;
      for (int j = 0; j <= smt_pkg::COS_ENTRIES; j++) begin
         r   = j;
         neg = 0;
         if (2 * j > smt_pkg::COS_ENTRIES) begin
            r   = smt_pkg::COS_ENTRIES - j;
            neg = 1;
         end
         y    = r * 64'd3373259426 / smt_pkg::COS_ENTRIES;
         y2   = (y * y) >> 30;
         term = 64'd1073741824;
         sum  = 64'sd1073741824;
         for (int k = 1; k <= 7; k++) begin
            term = ((term * y2) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2) sum -= longint'(term);
            else sum += longint'(term);
         end
         if (neg) sum = -sum;
         v = 64'sd1073741824 - sum;
         if (v < 0) v = 0;
         if (v > 64'sd2147483648) v = 64'sd2147483648;
         cos_w[j] = 17'((v + 16384) >>> 15);
      end
   endfunction

   function automatic longint unsigned taper_w(bit cosine, int k);
      longint unsigned x;
      if (k < 0) k = 0;
      x = longint'(k) * recip_r;
      if (x > 65536) x = 65536;
      if (!cosine) return x;
      return cos_w[(x * smt_pkg::COS_ENTRIES + 32768) >> 16];
   endfunction

   function automatic longint unsigned weight_mul(longint unsigned w, longint unsigned wt);
      return (w * wt + 32768) >> 16;
   endfunction

   function automatic smt_pkg::rsp_type mute_sample(smt_pkg::req_type q);
      longint          s, r;
      longint unsigned w;
      int              i, a, b, L, n, T, ms, me, ts1, te1, ts2, te2, fin, fz, wd, m, lo, hi;
      logic [2:0]      form;
      logic [1:0]      p;
      bit              cosine, active, muted, kill, spike, skip;
      smt_pkg::rsp_type o;
      s = longint'(q.sample_value);
      i = q.sample_index;
      a = q.mute_first;
      b = q.mute_second;
      L = trlen_r;
      if (L < 1) L = 1;
      if (L > smt_pkg::MAX_SAMPLES) L = smt_pkg::MAX_SAMPLES;
      n = L - 1;
      T = tlen_r;
      if (T > smt_pkg::MAX_TAPER) T = smt_pkg::MAX_TAPER;
      form   = form_r > 5 ? smt_pkg::FORM_COS_CENTER : form_r;
      cosine = form >= smt_pkg::FORM_COS_FIRST;
      p      = 2'(form % 3);
      active = i <= n;
      muted = 0; kill = 0; spike = 0; skip = 0;
      w = 65536;
      case (mode_r)
         smt_pkg::MODE_FRONT: begin
            me = a - 1;
            if (T > 0) begin
               ts1 = p == smt_pkg::PLACE_AT_MAX ? me - T + 1 :
                     p == smt_pkg::PLACE_AT_CENTER ? me - T / 2 + 1 : me + 1;
               te1 = ts1 + T;
               me  = ts1 - 1;
               if (i >= ts1 && i < te1)
                  w = weight_mul(w, taper_w(cosine, cosine ? i - ts1 : i - ts1 + 1));
            end
            kill  = me >= n;
            muted = i <= me;
         end
         smt_pkg::MODE_END: begin
            ms = a;
            if (T > 0) begin
               ts2 = p == smt_pkg::PLACE_AT_MAX ? ms :
                     p == smt_pkg::PLACE_AT_CENTER ? ms - T / 2 : ms - T;
               te2 = ts2 + T;
               ms  = te2;
               if (i >= ts2 && i < te2) w = weight_mul(w, taper_w(cosine, te2 - i));
            end
            kill  = ms <= 0;
            muted = i >= ms;
         end
         smt_pkg::MODE_IN: begin
            ms = a; me = b;
            if (T > 0) begin
               ts1 = p == smt_pkg::PLACE_AT_MAX ? ms :
                     p == smt_pkg::PLACE_AT_CENTER ? ms - T / 2 : ms - T;
               ts2 = p == smt_pkg::PLACE_AT_MAX ? me - T + 1 :
                     p == smt_pkg::PLACE_AT_CENTER ? me - T / 2 + 1 : me + 1;
               te1 = ts1 + T; ms = te1;
               te2 = ts2 + T; me = ts2 - 1;
               // nothing muted at all: the sample passes
               if (ts1 >= te2) skip = 1;
               else begin
                  fin = n; fz = 0;
                  // crossing tapers meet at the midpoint, which takes both weights
                  if (te1 > ts2) begin
                     fin = (te1 + ts2) / 2;
                     fz  = fin;
                  end
                  if (i >= ts1 && i < te1 && i <= fin)
                     w = weight_mul(w, taper_w(cosine, te1 - i));
                  if (i >= ts2 && i < te2 && i >= fz)
                     w = weight_mul(w, taper_w(cosine, cosine ? i - ts2 : i - ts2 + 1));
               end
            end
            if (!skip) begin
               kill  = me >= n && ms <= 0;
               muted = i >= ms && i <= me;
            end
         end
         smt_pkg::MODE_OUT: begin
            ms = a - 1; me = b + 1;
            if (T > 0) begin
               ts1 = p == smt_pkg::PLACE_AT_MAX ? ms - T + 1 :
                     p == smt_pkg::PLACE_AT_CENTER ? ms - T / 2 + 1 : ms + 1;
               ts2 = p == smt_pkg::PLACE_AT_MAX ? me :
                     p == smt_pkg::PLACE_AT_CENTER ? me - T / 2 : me - T;
               te1 = ts1 + T; ms = ts1 - 1;
               te2 = ts2 + T; me = te2;
               if (te1 < 0 && ts2 > n) skip = 1;
               else begin
                  if (i >= ts1 && i < te1)
                     w = weight_mul(w, taper_w(cosine, cosine ? i - ts1 : i - ts1 + 1));
                  if (i >= ts2 && i < te2) w = weight_mul(w, taper_w(cosine, te2 - i));
               end
            end
            if (!skip) begin
               kill  = ms >= me;
               muted = i <= ms || i >= me;
            end
         end
         smt_pkg::MODE_IND1, smt_pkg::MODE_IND2: begin
            wd = iwidth_r;
            for (int c = 0; c < (mode_r == smt_pkg::MODE_IND2 ? 2 : 1); c++) begin
               m  = c ? b : a;
               lo = m - wd < 0 ? 0 : m - wd;
               hi = m + wd < n ? m + wd : n;
               if (i >= lo && i < hi) spike = 1;
            end
         end
         default: ;
      endcase
      kill = kill && kill_r;
      if (kill) r = 0;
      else if (spike) r = longint'($signed(ival_r));
      else if (!active) r = s;
      else if (muted) r = 0;
      else r = (s * longint'(w) + 32768) >>> 16;
      o.out_value    = r[23:0];
      o.trace_killed = kill;
      o.last_out     = q.last_sample;
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      n_errors++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected item, out_value", rsp_data.out_value, 0);
         end else begin
            smt_pkg::rsp_type e;
            e = pending_samples.pop_front();
            n_results++;
            if (rsp_data.out_value !== e.out_value)
               report_mismatch("out_value", rsp_data.out_value, e.out_value);
            if (rsp_data.trace_killed !== e.trace_killed)
               report_mismatch("trace_killed", rsp_data.trace_killed, e.trace_killed);
            if (rsp_data.last_out !== e.last_out)
               report_mismatch("last_out", rsp_data.last_out, e.last_out);
         end
      end
   end

   // start is left high after an item so that back-to-back items need no toggle
   task automatic send_sample(smt_pkg::req_type q, bit idle_ok, bit typed,
                              smt_pkg::rsp_type e);
      if (idle_ok && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_data <= q;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_samples.push_back(typed ? e : mute_sample(q));
      n_items++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, int unsigned value);
      csr_index <= idx;
      csr_data  <= (smt_pkg::CSR_BITS)'(value);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         smt_pkg::REG_MUTE_MODE:      mode_r   = 3'(value);
         smt_pkg::REG_TAPER_FORM:     form_r   = 3'(value);
         smt_pkg::REG_TAPER_LENGTH:   tlen_r   = 9'(value);
         smt_pkg::REG_TAPER_RECIP:    recip_r  = 17'(value);
         smt_pkg::REG_TRACE_LENGTH:   trlen_r  = 13'(value);
         smt_pkg::REG_KILL_ENABLE:    kill_r   = 1'(value);
         smt_pkg::REG_INDICATE_VALUE: ival_r   = 24'(value);
         default:                     iwidth_r = 13'(value);
      endcase
   endtask

   // first phases pin the corners, the rest are random
   task automatic set_mute_config(int ph);
      int unsigned md, fm, tl, rc, trl, kl, iv, iw;
      case (ph)
         0: begin md = smt_pkg::MODE_FRONT; fm = 0; tl = 256; rc = 256; trl = 4096; kl = 1;
            iv = 24'h7FFFFF; iw = 0; end
         1: begin md = smt_pkg::MODE_END; fm = 5; tl = 8; rc = 8192; trl = 32; kl = 1;
            iv = 24'h000001; iw = 2; end
         2: begin md = smt_pkg::MODE_IN; fm = 1; tl = 16; rc = 4096; trl = 40; kl = 1;
            iv = 24'hFFFFFF; iw = 3; end
         3: begin md = smt_pkg::MODE_OUT; fm = 4; tl = 511; rc = 0; trl = 8191; kl = 0;
            iv = 24'h123456; iw = 8191; end
         4: begin md = smt_pkg::MODE_IND1; fm = 0; tl = 0; rc = 65536; trl = 20; kl = 1;
            iv = 24'h800000; iw = 4096; end
         5: begin md = smt_pkg::MODE_IND2; fm = 3; tl = 1; rc = 131071; trl = 0; kl = 0;
            iv = 24'h7FFFFF; iw = 0; end
         6: begin md = 6; fm = 6; tl = 5; rc = 13107; trl = 16; kl = 1; iv = 24'h5; iw = 1; end
         7: begin md = smt_pkg::MODE_IN; fm = 7; tl = 12; rc = 5461; trl = 30; kl = 1;
            iv = 24'h0; iw = 5; end
         default: begin
            md  = $urandom_range(0, 7);
            fm  = $urandom_range(0, 7);
            tl  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 20);
            rc  = (tl > 0 && $urandom_range(0, 3) != 0) ? (65536 + tl / 2) / tl
                                                        : $urandom_range(0, 131071);
            trl = $urandom_range(0, 7) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 48);
            kl  = $urandom_range(0, 1);
            iv  = $urandom_range(0, 24'hFFFFFF);
            iw  = $urandom_range(0, 7) == 0 ? $urandom_range(0, 8191) : $urandom_range(0, 6);
         end
      endcase
      write_reg(smt_pkg::REG_MUTE_MODE, md);
      write_reg(smt_pkg::REG_TAPER_FORM, fm);
      write_reg(smt_pkg::REG_TAPER_LENGTH, tl);
      write_reg(smt_pkg::REG_TAPER_RECIP, rc);
      write_reg(smt_pkg::REG_TRACE_LENGTH, trl);
      write_reg(smt_pkg::REG_KILL_ENABLE, kl);
      write_reg(smt_pkg::REG_INDICATE_VALUE, iv);
      write_reg(smt_pkg::REG_INDICATE_WIDTH, iw);
      csr_valid <= 1'b0;
   endtask

   // one trace with random mute indices near the samples, plus a little noise
   task automatic send_trace(int budget, output int sent);
      smt_pkg::req_type q;
      smt_pkg::rsp_type none;
      logic [63:0]      raw;
      int               eff, a, b, cnt, base;
      none = '0;
      eff  = trlen_r == 0 ? 1 :
             (trlen_r > smt_pkg::MAX_SAMPLES ? smt_pkg::MAX_SAMPLES : int'(trlen_r));
      a    = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191) : $urandom_range(0, eff + 8);
      b    = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191) : $urandom_range(a, a + 12);
      cnt  = eff <= 40 ? eff + $urandom_range(0, 2) : $urandom_range(8, 40);
      base = eff <= 40 ? 0 : a - int'($urandom_range(0, 20));
      if (base < 0) base = 0;
      if (cnt > budget) cnt = budget;
      for (int k = 0; k < cnt; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            raw = {$urandom, $urandom};
            q   = raw[62:0];
         end else begin
            q.sample_value = $urandom_range(0, 7) == 0 ?
                             ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000) : 24'($urandom);
            q.sample_index = 12'(base + k);
            q.mute_first   = 13'(a);
            q.mute_second  = 13'(b);
            q.last_sample  = k == cnt - 1;
         end
         send_sample(q, n_items < CALM_AFTER, 0, none);
      end
      sent = cnt;
   endtask

   dir_row_type dir_rows [] = '{
      '{24'h7FFFFF, 0,    0,    0,    0, 1, 24'h7FFFFF, 0},
      '{24'h800000, 4095, 0,    0,    1, 1, 24'h800000, 0},
      '{24'h00007B, 4095, 4096, 0,    0, 1, 24'h000000, 0},
      '{24'h000005, 9,    10,   0,    0, 1, 24'h000000, 0},
      '{24'h000005, 10,   10,   0,    1, 1, 24'h000005, 0},
      '{24'hFFFFFF, 0,    8191, 8191, 0, 1, 24'h000000, 0},
      '{24'h800000, 4095, 4095, 8191, 1, 0, 24'h0, 0},
      '{24'h555555, 2730, 2731, 5461, 0, 0, 24'h0, 0},
      '{24'hAAAAAA, 1365, 5461, 2730, 1, 0, 24'h0, 0},
      '{24'h000001, 4094, 4095, 4096, 0, 0, 24'h0, 0},
      '{24'hFFFFFE, 100,  50,   4096, 0, 0, 24'h0, 0},
      '{24'h400000, 2048, 4096, 4095, 1, 0, 24'h0, 0}
   };

   initial begin
      smt_pkg::req_type q;
      smt_pkg::rsp_type e;
      int      sent, in_phase;
      fill_cos_weights();
      // reset values of the block's registers
      mode_r = smt_pkg::MODE_FRONT; form_r = smt_pkg::FORM_COS_CENTER; tlen_r = 0;
      recip_r = smt_pkg::W_ONE;
      trlen_r = 13'd4096; kill_r = 0; ival_r = 0; iwidth_r = 13'd1;
      n_items = 0; n_results = 0; n_errors = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         q.sample_value = dir_rows[r].sv;
         q.sample_index = 12'(dir_rows[r].idx);
         q.mute_first   = 13'(dir_rows[r].a);
         q.mute_second  = 13'(dir_rows[r].b);
         q.last_sample  = dir_rows[r].last;
         e.out_value    = dir_rows[r].ev;
         e.trace_killed = dir_rows[r].ek;
         e.last_out     = dir_rows[r].last;
         send_sample(q, r % 3 == 1, dir_rows[r].typed, e);
      end
      drain();

      for (int ph = 0; ph < N_PHASES; ph++) begin
         set_mute_config(ph);
         in_phase = 0;
         while (in_phase < PHASE_ITEMS) begin
            send_trace(PHASE_ITEMS - in_phase, sent);
            in_phase += sent;
            // hold the sender off until the pipeline is empty
            if (ph == 9 && in_phase >= PHASE_ITEMS / 2 && in_phase - sent < PHASE_ITEMS / 2)
               drain();
         end
         drain();
      end

      repeat (10) @(posedge clock);
      $display("%0d sample items over %0d register settings, %0d results checked",
               n_items, N_PHASES + 1, n_results);
      $display("all mute modes, taper forms and indicate spikes exercised; %0d mismatches",
               n_errors);
      if (n_errors == 0 && pending_samples.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== seismic_trace_mute_taper.f =====
design/smt_pkg.sv
design/seismic_trace_mute_taper.sv
test/seismic_trace_mute_taper_tb.sv
